/* design/fqq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqq_pkg
// Shared types and constants for the queue with queries: item layouts,
// opcodes, status codes, cell control codes and the scan control group.
// ----------------------------------------------------------------------------
package fqq_pkg;

    // Queue geometry.
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 5;
    localparam int THIRD_POS = 3;

    // Opcodes.
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_MAX     = 3'd2;
    localparam logic [2:0] OP_SUM     = 3'd3;
    localparam logic [2:0] OP_THIRD   = 3'd4;
    localparam logic [2:0] OP_REVERSE = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Per-cell operation: keep, take the right neighbor, take the left
    // neighbor, or load the incoming value.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD  = 2'd0;
    localparam t_cell_op CELL_RIGHT = 2'd1;
    localparam t_cell_op CELL_LEFT  = 2'd2;
    localparam t_cell_op CELL_LOAD  = 2'd3;

    // Input and result items.
    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // Control for the scan unit during a walk around the chain.
    typedef struct packed {
        logic step;
        logic first;
        logic in_range;
        logic capture;
    } t_scan_ctl;

endpackage

`default_nettype wire

/* design/fqq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqq_cell
// One storage cell of the chain. It keeps one entry and, as told, takes
// the value of its left or right neighbor or loads the incoming value.
// ----------------------------------------------------------------------------
module fqq_cell (
    input  wire logic                          i_clk,
    input  wire fqq_pkg::t_cell_op             i_op,
    input  wire logic [fqq_pkg::DATA_W-1:0]    i_left,
    input  wire logic [fqq_pkg::DATA_W-1:0]    i_right,
    input  wire logic [fqq_pkg::DATA_W-1:0]    i_load,
    output logic      [fqq_pkg::DATA_W-1:0]    o_data
);

    logic [fqq_pkg::DATA_W-1:0] r_data;
    logic [fqq_pkg::DATA_W-1:0] n_data;

    // Select the next content of the cell.
    always_comb begin
        case (i_op)
            fqq_pkg::CELL_RIGHT: n_data = i_right;
            fqq_pkg::CELL_LEFT:  n_data = i_left;
            fqq_pkg::CELL_LOAD:  n_data = i_load;
            default:             n_data = r_data;
        endcase
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* design/fqq_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqq_scan
// Watches the tap at the head of the chain while the entries rotate past
// it and builds the largest entry, the wrapping sum and one captured entry.
// ----------------------------------------------------------------------------
module fqq_scan (
    input  wire logic                              i_clk,
    input  wire fqq_pkg::t_scan_ctl                i_ctl,
    input  wire logic signed [fqq_pkg::DATA_W-1:0] i_tap,
    output logic signed      [fqq_pkg::DATA_W-1:0] o_max,
    output logic signed      [fqq_pkg::DATA_W-1:0] o_sum,
    output logic signed      [fqq_pkg::DATA_W-1:0] o_cap
);

    logic signed [fqq_pkg::DATA_W-1:0] r_max;
    logic signed [fqq_pkg::DATA_W-1:0] r_sum;
    logic signed [fqq_pkg::DATA_W-1:0] r_cap;
    logic signed [fqq_pkg::DATA_W-1:0] n_max;
    logic signed [fqq_pkg::DATA_W-1:0] n_sum;
    logic signed [fqq_pkg::DATA_W-1:0] n_cap;

    // The first tap always holds a live entry, so it seeds both results.
    always_comb begin
        n_max = r_max;
        n_sum = r_sum;
        n_cap = r_cap;
        if (i_ctl.step) begin
            if (i_ctl.first) begin
                n_max = i_tap;
                n_sum = i_tap;
            end else if (i_ctl.in_range) begin
                if (i_tap > r_max) begin
                    n_max = i_tap;
                end
                n_sum = r_sum + i_tap;
            end
            if (i_ctl.capture) begin
                n_cap = i_tap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_max <= n_max;
        r_sum <= n_sum;
        r_cap <= n_cap;
    end

    assign o_max = r_max;
    assign o_sum = r_sum;
    assign o_cap = r_cap;

endmodule

`default_nettype wire

/* design/fifo_queue_with_queries_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_queries_unit
// Bounded queue of signed 32-bit entries held in a chain of cells, with
// push, pop, max, sum, third-entry and reverse operations.
// ----------------------------------------------------------------------------
// Push, forward pop, reverse and error cases go from accept through the
//   run and done states to the result; max, sum, third and reversed pop
//   add a walk, one full rotation of the cell chain past the scan tap.
// A new item is taken only once the previous result is registered at the output.
// Reset: synchronous, active low; the queue is empty and unreversed after
//   reset. Cell contents are not cleared.
module fifo_queue_with_queries_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fqq_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fqq_pkg::t_out_item      o_out_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [fqq_pkg::IDX_W-1:0] IDX_LAST  = fqq_pkg::IDX_W'(fqq_pkg::DEPTH - 1);
    localparam logic [fqq_pkg::CNT_W-1:0] CNT_FULL  = fqq_pkg::CNT_W'(fqq_pkg::DEPTH);
    localparam logic [fqq_pkg::CNT_W-1:0] CNT_ONE   = fqq_pkg::CNT_W'(1);
    localparam logic [fqq_pkg::CNT_W-1:0] CNT_THIRD = fqq_pkg::CNT_W'(fqq_pkg::THIRD_POS);
    localparam logic [fqq_pkg::CNT_W-1:0] CNT_TWO   = fqq_pkg::CNT_W'(fqq_pkg::THIRD_POS - 1);

    // Control state.
    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [fqq_pkg::CNT_W-1:0]   r_count;
    logic [fqq_pkg::CNT_W-1:0]   n_count;
    logic                        r_rev;
    logic                        n_rev;
    logic [fqq_pkg::IDX_W-1:0]   r_k;
    logic [fqq_pkg::IDX_W-1:0]   n_k;
    logic                        r_out_valid;
    logic                        n_out_valid;

    // Payload state.
    logic [2:0]                         r_op;
    logic [2:0]                         n_op;
    logic [fqq_pkg::DATA_W-1:0]         r_val;
    logic [fqq_pkg::DATA_W-1:0]         n_val;
    logic signed [fqq_pkg::DATA_W-1:0]  r_res;
    logic signed [fqq_pkg::DATA_W-1:0]  n_res;
    logic [1:0]                         r_st;
    logic [1:0]                         n_st;
    logic                               r_use_scan;
    logic                               n_use_scan;
    fqq_pkg::t_out_item                 r_out;
    fqq_pkg::t_out_item                 n_out;

    // Chain and scan wiring.
    logic [fqq_pkg::DATA_W-1:0]         w_cell [fqq_pkg::DEPTH];
    fqq_pkg::t_cell_op                  w_cell_op [fqq_pkg::DEPTH];
    fqq_pkg::t_scan_ctl                 w_scan_ctl;
    logic signed [fqq_pkg::DATA_W-1:0]  w_max;
    logic signed [fqq_pkg::DATA_W-1:0]  w_sum;
    logic signed [fqq_pkg::DATA_W-1:0]  w_cap;
    logic [fqq_pkg::CNT_W-1:0]          w_target;
    logic signed [fqq_pkg::DATA_W-1:0]  w_result;
    logic                               w_out_free;
    logic                               w_full;
    logic                               w_empty;

    assign w_full     = (r_count == CNT_FULL);
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Cell chain: each cell takes its right neighbor, the last cell wrapping to
    // the first, so that a walk rotates the whole row; a shift toward the tail
    // feeds the incoming value into the first cell and each left neighbor on.
    for (genvar i = 0; i < fqq_pkg::DEPTH; i++) begin : g_cell
        localparam int RIGHT = (i + 1) % fqq_pkg::DEPTH;
        logic [fqq_pkg::DATA_W-1:0] w_left;

        if (i == 0) begin : g_first
            assign w_left = r_val;
        end else begin : g_rest
            assign w_left = w_cell[i-1];
        end

        // Per-cell operation for this cycle.
        always_comb begin
            w_cell_op[i] = fqq_pkg::CELL_HOLD;
            if (r_state == S_RUN) begin
                if (r_op == fqq_pkg::OP_PUSH && !w_full) begin
                    if (r_rev) begin
                        w_cell_op[i] = fqq_pkg::CELL_LEFT;
                    end else if (r_count == fqq_pkg::CNT_W'(i)) begin
                        w_cell_op[i] = fqq_pkg::CELL_LOAD;
                    end
                end else if (r_op == fqq_pkg::OP_POP && !w_empty && !r_rev) begin
                    w_cell_op[i] = fqq_pkg::CELL_RIGHT;
                end
            end else if (r_state == S_WALK) begin
                w_cell_op[i] = fqq_pkg::CELL_RIGHT;
            end
        end

        fqq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op[i]),
            .i_left  (w_left),
            .i_right (w_cell[RIGHT]),
            .i_load  (r_val),
            .o_data  (w_cell[i])
        );
    end

    // Physical position to capture: the oldest entry for a reversed pop,
    // the third-oldest for a third query.
    always_comb begin
        if (r_op == fqq_pkg::OP_POP) begin
            w_target = r_count - CNT_ONE;
        end else if (r_rev) begin
            w_target = r_count - CNT_THIRD;
        end else begin
            w_target = CNT_TWO;
        end
    end

    assign w_scan_ctl.step     = (r_state == S_WALK);
    assign w_scan_ctl.first    = (r_k == '0);
    assign w_scan_ctl.in_range = (fqq_pkg::CNT_W'(r_k) < r_count);
    assign w_scan_ctl.capture  = (fqq_pkg::CNT_W'(r_k) == w_target);

    fqq_scan u_scan (
        .i_clk (i_clk),
        .i_ctl (w_scan_ctl),
        .i_tap (w_cell[0]),
        .o_max (w_max),
        .o_sum (w_sum),
        .o_cap (w_cap)
    );

    // Final result: a walk answers from the scan unit.
    always_comb begin
        w_result = r_res;
        if (r_use_scan) begin
            case (r_op)
                fqq_pkg::OP_MAX: w_result = w_max;
                fqq_pkg::OP_SUM: w_result = w_sum;
                default:         w_result = w_cap;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rev       = r_rev;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_val       = r_val;
        n_res       = r_res;
        n_st        = r_st;
        n_use_scan  = r_use_scan;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_item.opcode;
                    n_val   = i_in_item.value;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_state    = S_DONE;
                n_res      = '0;
                n_st       = fqq_pkg::ST_OK;
                n_use_scan = 1'b0;
                n_k        = '0;
                case (r_op)
                    fqq_pkg::OP_PUSH: begin
                        if (w_full) begin
                            n_st = fqq_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + CNT_ONE;
                        end
                    end
                    fqq_pkg::OP_POP: begin
                        if (w_empty) begin
                            n_st = fqq_pkg::ST_EMPTY;
                        end else if (r_rev) begin
                            n_state = S_WALK;
                        end else begin
                            n_res   = w_cell[0];
                            n_count = r_count - CNT_ONE;
                            if (r_count == CNT_ONE) begin
                                n_rev = 1'b0;
                            end
                        end
                    end
                    fqq_pkg::OP_MAX, fqq_pkg::OP_SUM: begin
                        if (w_empty) begin
                            n_st = fqq_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    fqq_pkg::OP_THIRD: begin
                        if (r_count < CNT_THIRD) begin
                            n_st = fqq_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    fqq_pkg::OP_REVERSE: begin
                        if (w_empty) begin
                            n_st = fqq_pkg::ST_EMPTY;
                        end else begin
                            n_rev = !r_rev;
                        end
                    end
                    default: begin
                        n_st = fqq_pkg::ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                // One full rotation brings every cell back to its place.
                n_k = r_k + 1'b1;
                if (r_k == IDX_LAST) begin
                    n_k        = '0;
                    n_state    = S_DONE;
                    n_use_scan = 1'b1;
                    if (r_op == fqq_pkg::OP_POP) begin
                        n_count = r_count - CNT_ONE;
                        if (r_count == CNT_ONE) begin
                            n_rev = 1'b0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.result    = w_result;
                    n_out.status    = r_st;
                    n_out.occupancy = fqq_pkg::OCC_W'(r_count);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_res      <= n_res;
        r_st       <= n_st;
        r_use_scan <= n_use_scan;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the queue with queries. A short directed sequence covers
// the empty and full queue, the signed extremes, too few entries for the
// third-entry query, pops and pushes while reversed, and the unused
// opcodes. Random traffic follows in phases with different sender gaps
// and receiver stalls. Every accepted item goes through a local model of
// the queue. Every result is compared field by field with the oldest
// pending expectation.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The two opcodes that the block treats as no operation.
    localparam logic [2:0] OP_NOP_A = 3'd6;
    localparam logic [2:0] OP_NOP_B = 3'd7;

    localparam int RAND_ITEMS = 1000;
    localparam int PHASES     = 5;
    localparam int PHASE_IDLE  [PHASES] = '{0, 80, 0, 31, 0};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 80, 31, 0};

    // One row of the directed sequence. The golden result is used only
    // when typed is set. Otherwise the local queue model supplies it.
    typedef struct packed {
        logic [2:0]         opcode;
        logic [31:0]        value;
        logic [5:0]         reps;
        logic               typed;
        fqq_pkg::t_out_item golden;
    } t_seq_row;

    localparam int DIR_ROWS = 26;
    localparam t_seq_row DIRECTED [DIR_ROWS] = '{
        '{fqq_pkg::OP_POP, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}},
        '{fqq_pkg::OP_MAX, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}},
        '{fqq_pkg::OP_SUM, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}},
        '{fqq_pkg::OP_THIRD, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}},
        '{fqq_pkg::OP_REVERSE, 32'h0000_0000, 6'd1, 1'b1,
          '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}},
        '{OP_NOP_A, 32'hFFFF_FFFF, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd0}},
        '{OP_NOP_B, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd0}},
        '{fqq_pkg::OP_PUSH, 32'h7FFF_FFFF, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd1}},
        '{fqq_pkg::OP_PUSH, 32'h8000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd2}},
        '{fqq_pkg::OP_THIRD, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd2}},
        '{fqq_pkg::OP_MAX, 32'h0000_0000, 6'd1, 1'b1,
          '{32'sh7FFF_FFFF, fqq_pkg::ST_OK, 5'd2}},
        '{fqq_pkg::OP_SUM, 32'h0000_0000, 6'd1, 1'b1,
          '{32'shFFFF_FFFF, fqq_pkg::ST_OK, 5'd2}},
        '{fqq_pkg::OP_PUSH, 32'hFFFF_FFFF, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd3}},
        '{fqq_pkg::OP_THIRD, 32'h0000_0000, 6'd1, 1'b1,
          '{32'shFFFF_FFFF, fqq_pkg::ST_OK, 5'd3}},
        '{fqq_pkg::OP_REVERSE, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_OK, 5'd3}},
        '{fqq_pkg::OP_THIRD, 32'h0000_0000, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_POP, 32'hFFFF_FFFF, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_PUSH, 32'h5555_5555, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_PUSH, 32'hAAAA_AAAA, 6'd13, 1'b0, '0},
        '{fqq_pkg::OP_PUSH, 32'h1234_5678, 6'd1, 1'b1,
          '{32'sh0, fqq_pkg::ST_FULL, 5'd16}},
        '{fqq_pkg::OP_SUM, 32'h0000_0000, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_MAX, 32'h0000_0000, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_REVERSE, 32'h0000_0000, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_THIRD, 32'h0000_0000, 6'd1, 1'b0, '0},
        '{fqq_pkg::OP_POP, 32'h0000_0000, 6'd16, 1'b0, '0},
        '{fqq_pkg::OP_POP, 32'h0000_0000, 6'd1, 1'b1, '{32'sh0, fqq_pkg::ST_EMPTY, 5'd0}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    fqq_pkg::t_in_item  in_item = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    fqq_pkg::t_out_item out_item;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    fqq_pkg::t_out_item pending_results [$];

    // Local copy of the queue: ring of entries, head, count, reversed flag.
    logic signed [fqq_pkg::DATA_W-1:0] q_entries [fqq_pkg::DEPTH];
    int q_head = 0;
    int q_count = 0;
    bit q_flipped = 1'b0;

    fifo_queue_with_queries_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #6 clk = ~clk;

    // Ring slot of logical position pos, where zero is the oldest entry.
    function automatic int slot_at(int pos);
        int off;
        off = q_flipped ? (q_count - 1 - pos) : pos;
        return (q_head + off) % fqq_pkg::DEPTH;
    endfunction

    // Applies one item to the local queue and returns the result it gives.
    function automatic fqq_pkg::t_out_item predict_queue_op(fqq_pkg::t_in_item it);
        fqq_pkg::t_out_item r;
        logic signed [fqq_pkg::DATA_W-1:0] best;
        logic [fqq_pkg::DATA_W-1:0] acc;
        r = '0;
        r.status = fqq_pkg::ST_OK;
        case (it.opcode)
            fqq_pkg::OP_PUSH: begin
                if (q_count >= fqq_pkg::DEPTH) begin
                    r.status = fqq_pkg::ST_FULL;
                end else if (q_flipped) begin
                    q_head = (q_head + fqq_pkg::DEPTH - 1) % fqq_pkg::DEPTH;
                    q_entries[q_head] = it.value;
                    q_count++;
                end else begin
                    q_entries[(q_head + q_count) % fqq_pkg::DEPTH] = it.value;
                    q_count++;
                end
            end
            fqq_pkg::OP_POP: begin
                if (q_count == 0) begin
                    r.status = fqq_pkg::ST_EMPTY;
                end else begin
                    r.result = q_entries[slot_at(0)];
                    if (!q_flipped) begin
                        q_head = (q_head + 1) % fqq_pkg::DEPTH;
                    end
                    q_count--;
                    // An emptied queue starts over unreversed at slot zero.
                    if (q_count == 0) begin
                        q_head = 0;
                        q_flipped = 1'b0;
                    end
                end
            end
            fqq_pkg::OP_MAX: begin
                if (q_count == 0) begin
                    r.status = fqq_pkg::ST_EMPTY;
                end else begin
                    best = q_entries[slot_at(0)];
                    for (int k = 1; k < q_count; k++) begin
                        if (q_entries[slot_at(k)] > best) begin
                            best = q_entries[slot_at(k)];
                        end
                    end
                    r.result = best;
                end
            end
            fqq_pkg::OP_SUM: begin
                if (q_count == 0) begin
                    r.status = fqq_pkg::ST_EMPTY;
                end else begin
                    acc = '0;
                    for (int k = 0; k < q_count; k++) begin
                        acc = acc + q_entries[slot_at(k)];
                    end
                    r.result = acc;
                end
            end
            fqq_pkg::OP_THIRD: begin
                if (q_count < fqq_pkg::THIRD_POS) begin
                    r.status = fqq_pkg::ST_EMPTY;
                end else begin
                    r.result = q_entries[slot_at(fqq_pkg::THIRD_POS - 1)];
                end
            end
            fqq_pkg::OP_REVERSE: begin
                if (q_count == 0) begin
                    r.status = fqq_pkg::ST_EMPTY;
                end else begin
                    q_flipped = !q_flipped;
                end
            end
            default: begin
            end
        endcase
        r.occupancy = q_count[fqq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // Random item with the given shares of pushes and pops, in percent.
    // Values lean toward the signed extremes and small numbers.
    function automatic fqq_pkg::t_in_item random_item(int push_pct, int pop_pct);
        fqq_pkg::t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            it.opcode = fqq_pkg::OP_PUSH;
        end else if (r < push_pct + pop_pct) begin
            it.opcode = fqq_pkg::OP_POP;
        end else if (r < 97) begin
            case ($urandom_range(0, 3))
                0: it.opcode = fqq_pkg::OP_MAX;
                1: it.opcode = fqq_pkg::OP_SUM;
                2: it.opcode = fqq_pkg::OP_THIRD;
                default: it.opcode = fqq_pkg::OP_REVERSE;
            endcase
        end else begin
            it.opcode = ($urandom_range(0, 1) != 0) ? OP_NOP_B : OP_NOP_A;
        end
        case ($urandom_range(0, 7))
            0: it.value = 32'sh8000_0000;
            1: it.value = 32'sh7FFF_FFFF;
            2: it.value = -32'sd1;
            3: it.value = $urandom_range(0, 20);
            default: it.value = $urandom();
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Offers one item after random gaps, waits until it is taken, then
    // records the result that it should cause.
    task automatic send_item(input fqq_pkg::t_in_item it, input bit typed,
                             input fqq_pkg::t_out_item golden);
        fqq_pkg::t_out_item want;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = predict_queue_op(it);
        pending_results.push_back(typed ? golden : want);
    endtask

    // Holds the sender off until every pending result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Receiver: random stalls and the comparison of each result taken.
    always @(posedge clk) begin : result_check
        fqq_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", out_item.result, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_item.result !== want.result) begin
                    report_mismatch("result", out_item.result, want.result);
                end
                if (out_item.status !== want.status) begin
                    report_mismatch("status", out_item.status, want.status);
                end
                if (out_item.occupancy !== want.occupancy) begin
                    report_mismatch("occupancy", out_item.occupancy, want.occupancy);
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Stimulus: reset, the directed sequence, then random phases.
    initial begin
        fqq_pkg::t_in_item item;
        int push_pct;
        int pop_pct;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            for (int k = 0; k < DIRECTED[i].reps; k++) begin
                item.opcode = DIRECTED[i].opcode;
                item.value  = DIRECTED[i].value;
                send_item(item, DIRECTED[i].typed, DIRECTED[i].golden);
            end
        end
        wait_drained();

        // The push and pop shares change every 50 items, so that the queue
        // swings between empty and full.
        push_pct = 0;
        pop_pct = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = PHASE_IDLE[ph];
            stall_pct = PHASE_STALL[ph];
            for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
                if (n % 50 == 0) begin
                    push_pct = $urandom_range(10, 60);
                    pop_pct  = $urandom_range(10, 60);
                end
                send_item(random_item(push_pct, pop_pct), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (2 * fqq_pkg::DEPTH + 8) @(posedge clk);
        if (mismatches == 0) begin
            $display("fifo_queue_with_queries_unit verification clean");
        end else begin
            $display("fifo_queue_with_queries_unit verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("fifo_queue_with_queries_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
design/fqq_pkg.sv
design/fqq_cell.sv
design/fqq_scan.sv
design/fifo_queue_with_queries_unit.sv
test/tb.sv
